FILE: rtl/tmc_pkg.sv
// tmc_pkg: shared types and constants of the text-mode console.
// Used by tmc_ctrl, tmc_datapath and text_mode_console; depends on nothing.
`default_nettype none

package tmc_pkg;

    // field widths fixed by the stream and register layout
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;

    // default store geometry
    localparam int DEF_MAX_COLUMNS = 80;
    localparam int DEF_MAX_ROWS    = 25;

    // register reset values
    localparam logic [COL_W-1:0] RST_COLUMNS = 7'd80;
    localparam logic [ROW_W-1:0] RST_ROWS    = 5'd25;

    // register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // cell words
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [CELL_W-1:0] TEXT_ATTR  = 16'h0F00;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CK_NUL,
        CK_BS,
        CK_LF,
        CK_CR,
        CK_PRINT
    } ch_kind_t;

    typedef enum logic [1:0] {
        SW_NONE,
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } sweep_t;

    typedef struct packed {
        logic   load;
        logic   fix;
        logic   newline;
        logic   cret;
        logic   bksp;
        logic   col_inc;
        logic   calc_addr;
        logic   cell_write;
        logic   home;
        logic   out_load;
        sweep_t sweep;
    } cmd_t;

    typedef struct packed {
        logic     fix_scroll;
        logic     sweep_last;
        logic     col_zero;
        logic     out_free;
        mode_t    mode;
        ch_kind_t ch_kind;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/text_mode_console.sv
// text_mode_console: top level of the character-cell text console.
// Depends on tmc_pkg, tmc_ctrl and tmc_datapath.
`default_nettype none

// Channel   Dir  Ports                          Payload
// --------  ---  -----------------------------  ---------------------------------
// input     in   s_tvalid/s_tready/s_tdata/     tuser: mode; tdata: char_code,
//                s_tuser                        cell_index
// result    out  m_tvalid/m_tready/m_tdata      cell_value, cursor_col, cursor_row
// config    in   cfg_wr_en/cfg_addr/cfg_wdata   0 columns, 1 rows
//
// Each scroll and each clear sweeps the active area (columns*rows cells):
//   the screen store has one write and one read port, and the sweep moves
//   one cell per cycle.
// Reset: after aresetn the whole store (MAX_COLUMNS*MAX_ROWS cells, 2000 by
//   default) is blanked with s_tready low; config writes are taken meanwhile.
// Stalls: a result waits in the output register; the next transfer is
//   accepted meanwhile and holds in its last cycle until the register frees.

module text_mode_console #(
    parameter int MAX_COLUMNS = tmc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tmc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input channel
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // [7:0] char_code, [18:8] cell_index
    input  wire logic [1:0]                s_tuser,   // [1:0] mode
    // result channel
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,   // [15:0] cell_value,
                                                      // [22:16] cursor_col, [27:23] cursor_row
    // config write port
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_addr,
    input  wire logic [tmc_pkg::COL_W-1:0] cfg_wdata
);

    tmc_pkg::cmd_t    cmd;
    tmc_pkg::status_t sts;

    // sequencer: decides each step of put/read/clear and the sweeps
    tmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, cursor, config and result register
    tmc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/tmc_ctrl.sv
// tmc_ctrl: sequencer of the text-mode console (one-hot state machine).
// Depends on tmc_pkg; drives tmc_datapath through cmd_t / status_t.
`default_nettype none

module tmc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire tmc_pkg::status_t sts,
    output tmc_pkg::cmd_t         cmd
);

    typedef enum logic [10:0] {
        S_INIT     = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISPATCH = 11'b000_0000_0100,
        S_FIX      = 11'b000_0000_1000,
        S_SCROLL   = 11'b000_0001_0000,
        S_ACT      = 11'b000_0010_0000,
        S_ADDR     = 11'b000_0100_0000,
        S_WRITE    = 11'b000_1000_0000,
        S_READ     = 11'b001_0000_0000,
        S_CLEAR    = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   nl_reg, nl_next;   // second fix-up pass after a newline

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            nl_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nl_reg    <= nl_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        nl_next    = nl_reg;
        cmd        = '0;
        cmd.sweep  = tmc_pkg::SW_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep = tmc_pkg::SW_INIT;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                nl_next  = 1'b0;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.mode)
                    tmc_pkg::MODE_PUT:   state_next = S_FIX;
                    tmc_pkg::MODE_READ:  state_next = S_READ;
                    tmc_pkg::MODE_CLEAR: state_next = S_CLEAR;
                    default:             state_next = S_DONE;
                endcase
            end
            S_FIX: begin
                cmd.fix = 1'b1;
                if (sts.fix_scroll) state_next = S_SCROLL;
                else                state_next = nl_reg ? S_DONE : S_ACT;
            end
            S_SCROLL: begin
                cmd.sweep = tmc_pkg::SW_SCROLL;
                if (sts.sweep_last) state_next = nl_reg ? S_DONE : S_ACT;
            end
            S_ACT: begin
                unique case (sts.ch_kind)
                    tmc_pkg::CK_NUL: state_next = S_DONE;
                    tmc_pkg::CK_BS: begin
                        if (sts.col_zero) begin
                            state_next = S_DONE;
                        end else begin
                            cmd.bksp   = 1'b1;
                            state_next = S_ADDR;
                        end
                    end
                    tmc_pkg::CK_LF: begin
                        cmd.newline = 1'b1;
                        nl_next     = 1'b1;
                        state_next  = S_FIX;
                    end
                    tmc_pkg::CK_CR: begin
                        cmd.cret   = 1'b1;
                        state_next = S_DONE;
                    end
                    default: state_next = S_ADDR;
                endcase
            end
            S_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE: begin
                cmd.cell_write = 1'b1;
                cmd.col_inc    = (sts.ch_kind == tmc_pkg::CK_PRINT);
                state_next     = S_DONE;
            end
            S_READ: state_next = S_DONE;
            S_CLEAR: begin
                cmd.sweep = tmc_pkg::SW_CLEAR;
                if (sts.sweep_last) begin
                    cmd.home   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tmc_datapath.sv
// tmc_datapath: screen store, cursor, config registers, sweep counter and
// result register of the text-mode console. Depends on tmc_pkg.
`default_nettype none

module tmc_datapath #(
    parameter int MAX_COLUMNS = tmc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tmc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tmc_pkg::cmd_t               cmd,
    output tmc_pkg::status_t                 sts,
    input  wire logic [23:0]                 s_tdata,
    input  wire logic [1:0]                  s_tuser,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_addr,
    input  wire logic [tmc_pkg::COL_W-1:0]   cfg_wdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata
);

    localparam int STORE   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W  = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int AREA_W  = $clog2(STORE + 1);
    localparam int COL_MAX = (1 << tmc_pkg::COL_W) - 1;
    localparam int ROW_MAX = (1 << tmc_pkg::ROW_W) - 1;
    localparam logic [tmc_pkg::COL_W-1:0] COL_CAP =
        tmc_pkg::COL_W'((MAX_COLUMNS > COL_MAX) ? COL_MAX : MAX_COLUMNS);
    localparam logic [tmc_pkg::ROW_W-1:0] ROW_CAP =
        tmc_pkg::ROW_W'((MAX_ROWS > ROW_MAX) ? ROW_MAX : MAX_ROWS);

    // config
    logic [tmc_pkg::COL_W-1:0] cols_reg;
    logic [tmc_pkg::ROW_W-1:0] rows_reg;
    logic [tmc_pkg::COL_W-1:0] w;
    logic [tmc_pkg::ROW_W-1:0] h;
    logic [AREA_W-1:0]         area_reg, move_reg;

    // item
    tmc_pkg::mode_t              mode_reg;
    logic [tmc_pkg::CHAR_W-1:0]  char_reg;
    logic [tmc_pkg::INDEX_W-1:0] idx_reg;
    logic                        idx_ok;

    // cursor
    logic [tmc_pkg::COL_W-1:0] col_reg, col_next;
    logic [tmc_pkg::ROW_W-1:0] line_reg, line_next;
    logic                      col_ge;
    logic [tmc_pkg::ROW_W:0]   line_a;
    logic                      fix_scroll;

    // store access
    logic [tmc_pkg::CELL_W-1:0] mem [STORE];
    logic [tmc_pkg::CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [12:0]                cell_lin;
    logic [ADDR_W-1:0]          addr_reg;
    logic [AREA_W-1:0]          cnt_reg, cnt_next;
    logic                       sweep_last;
    logic                       wb_valid_reg, wb_valid_next;
    logic                       wb_from_rd_reg, wb_from_rd_next;
    logic [ADDR_W-1:0]          wb_addr_reg, wb_addr_next;
    logic [tmc_pkg::CELL_W-1:0] wb_data_reg, wb_data_next;

    // result
    logic                       out_valid_reg;
    logic [tmc_pkg::CELL_W-1:0] out_value_reg;
    logic [tmc_pkg::COL_W-1:0]  out_col_reg;
    logic [tmc_pkg::ROW_W-1:0]  out_row_reg;
    tmc_pkg::ch_kind_t          ch_kind;

    // out-of-range register values clamp into the store
    always_comb begin
        priority if (cols_reg == '0)    w = tmc_pkg::COL_W'(1);
        else if (cols_reg > COL_CAP)    w = COL_CAP;
        else                            w = cols_reg;
        priority if (rows_reg == '0)    h = tmc_pkg::ROW_W'(1);
        else if (rows_reg > ROW_CAP)    h = ROW_CAP;
        else                            h = rows_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= tmc_pkg::RST_COLUMNS;
            rows_reg <= tmc_pkg::RST_ROWS;
        end else if (cfg_wr_en) begin
            if (cfg_addr == tmc_pkg::REG_COLUMNS) cols_reg <= cfg_wdata;
            if (cfg_addr == tmc_pkg::REG_ROWS)    rows_reg <= cfg_wdata[tmc_pkg::ROW_W-1:0];
        end
    end

    // active area and scroll move length, one product each
    always_ff @(posedge aclk) begin
        area_reg <= AREA_W'(12'(w) * 12'(h));
        move_reg <= AREA_W'(12'(w) * 12'(h - tmc_pkg::ROW_W'(1)));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= tmc_pkg::mode_t'(s_tuser);
            char_reg <= s_tdata[7:0];
            idx_reg  <= s_tdata[18:8];
        end
    end

    assign idx_ok = (32'(idx_reg) < 32'(STORE));

    always_comb begin
        unique case (char_reg)
            tmc_pkg::CH_NUL: ch_kind = tmc_pkg::CK_NUL;
            tmc_pkg::CH_BS:  ch_kind = tmc_pkg::CK_BS;
            tmc_pkg::CH_LF:  ch_kind = tmc_pkg::CK_LF;
            tmc_pkg::CH_CR:  ch_kind = tmc_pkg::CK_CR;
            default:         ch_kind = tmc_pkg::CK_PRINT;
        endcase
    end

    // cursor fix-up: wrap a pending column, then clamp the row (scroll)
    assign col_ge     = (col_reg >= w);
    assign line_a     = {1'b0, line_reg} + (tmc_pkg::ROW_W+1)'(col_ge);
    assign fix_scroll = (line_a >= {1'b0, h});

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        priority if (cmd.home) begin
            col_next  = '0;
            line_next = '0;
        end else if (cmd.fix) begin
            col_next  = col_ge ? '0 : col_reg;
            line_next = fix_scroll ? (h - tmc_pkg::ROW_W'(1))
                                   : line_a[tmc_pkg::ROW_W-1:0];
        end else if (cmd.newline) begin
            col_next  = '0;
            line_next = line_reg + tmc_pkg::ROW_W'(1);
        end else if (cmd.cret) begin
            col_next  = '0;
        end else if (cmd.bksp) begin
            col_next  = col_reg - tmc_pkg::COL_W'(1);
        end else if (cmd.col_inc) begin
            col_next  = col_reg + tmc_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    assign cell_lin = 13'(line_reg) * 13'(w) + 13'(col_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc_addr) addr_reg <= ADDR_W'(cell_lin);
    end

    // sweep counter and write-back stage (the one write port of the store)
    always_comb begin
        cnt_next        = (cmd.sweep == tmc_pkg::SW_NONE) ? '0 : cnt_reg + AREA_W'(1);
        wb_valid_next   = 1'b0;
        wb_from_rd_next = 1'b0;
        wb_addr_next    = cnt_reg[ADDR_W-1:0];
        wb_data_next    = tmc_pkg::BLANK_CELL;
        rd_addr         = idx_ok ? ADDR_W'(idx_reg) : '0;
        unique case (cmd.sweep)
            tmc_pkg::SW_NONE: begin
                if (cmd.cell_write) begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = addr_reg;
                    wb_data_next  = (ch_kind == tmc_pkg::CK_BS) ? tmc_pkg::BLANK_CELL
                                  : (tmc_pkg::TEXT_ATTR | tmc_pkg::CELL_W'(char_reg));
                end
            end
            tmc_pkg::SW_INIT, tmc_pkg::SW_CLEAR: wb_valid_next = 1'b1;
            tmc_pkg::SW_SCROLL: begin
                wb_valid_next = 1'b1;
                if (cnt_reg < move_reg) begin
                    wb_from_rd_next = 1'b1;
                    rd_addr         = ADDR_W'(cnt_reg + AREA_W'(w));
                end
            end
            default: wb_valid_next = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.sweep)
            tmc_pkg::SW_INIT: sweep_last = (cnt_reg == AREA_W'(STORE - 1));
            tmc_pkg::SW_NONE: sweep_last = 1'b0;
            default:          sweep_last = (cnt_reg == area_reg - AREA_W'(1));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            wb_valid_reg <= wb_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_from_rd_reg <= wb_from_rd_next;
        wb_addr_reg    <= wb_addr_next;
        wb_data_reg    <= wb_data_next;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wb_valid_reg) begin
            mem[wb_addr_reg] <= wb_from_rd_reg ? rd_data_reg : wb_data_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= (mode_reg == tmc_pkg::MODE_READ && idx_ok) ? rd_data_reg : '0;
            out_col_reg   <= col_reg;
            out_row_reg   <= line_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_row_reg, out_col_reg, out_value_reg};

    assign sts.fix_scroll = fix_scroll;
    assign sts.sweep_last = sweep_last;
    assign sts.col_zero   = (col_reg == '0);
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.mode       = mode_reg;
    assign sts.ch_kind    = ch_kind;

endmodule

`default_nettype wire

FILE: sim/console_checker.sv
// console_checker: watches the text console's input stream, result stream and
// register port, keeps its own screen, cursor and geometry, and checks results.
// Depends on tmc_pkg only.

module console_checker #(
    parameter int MAX_COLUMNS = tmc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tmc_pkg::DEF_MAX_ROWS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [23:0]               s_tdata,    // [7:0] char_code, [18:8] cell_index
    input  logic [1:0]                s_tuser,    // [1:0] mode
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [31:0]               m_tdata,    // [15:0] cell_value, [22:16] cursor_col,
                                                  // [27:23] cursor_row
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [tmc_pkg::COL_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        outstanding
);

    localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

    // member order matches m_tdata[27:0]
    typedef struct packed {
        logic [tmc_pkg::ROW_W-1:0]  row;
        logic [tmc_pkg::COL_W-1:0]  col;
        logic [tmc_pkg::CELL_W-1:0] cell_word;
    } console_view_t;

    logic [tmc_pkg::CELL_W-1:0] screen [STORE_CELLS];
    int                         cur_col;
    int                         cur_row;
    logic [tmc_pkg::COL_W-1:0]  columns_reg;
    logic [tmc_pkg::ROW_W-1:0]  rows_reg;
    console_view_t              awaited_views [$];
    int                         mismatches;

    // out-of-range register values clip to 1 .. MAX_COLUMNS and 1 .. MAX_ROWS
    function automatic int area_width();
        if (columns_reg == '0) return 1;
        if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(columns_reg);
    endfunction

    function automatic int area_height();
        if (rows_reg == '0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic void scroll_up(int w, int h);
        for (int i = 0; i < w * (h - 1); i++) screen[i] = screen[i + w];
        for (int i = w * (h - 1); i < w * h; i++) screen[i] = tmc_pkg::BLANK_CELL;
    endfunction

    // pending wrap first, then scroll if the cursor fell off the bottom
    function automatic void settle_cursor(int w, int h);
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) begin
            cur_row = h - 1;
            scroll_up(w, h);
        end
    endfunction

    function automatic void put_char(logic [tmc_pkg::CHAR_W-1:0] ch);
        int w;
        int h;
        w = area_width();
        h = area_height();
        settle_cursor(w, h);
        case (ch)
            tmc_pkg::CH_NUL: ;
            tmc_pkg::CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    screen[cur_row * w + cur_col] = tmc_pkg::BLANK_CELL;
                end
            end
            tmc_pkg::CH_LF: begin
                cur_row++;
                cur_col = 0;
                settle_cursor(w, h);
            end
            tmc_pkg::CH_CR: cur_col = 0;
            default: begin
                screen[cur_row * w + cur_col] = tmc_pkg::TEXT_ATTR | tmc_pkg::CELL_W'(ch);
                cur_col++;
            end
        endcase
    endfunction

    function automatic console_view_t step_console(tmc_pkg::mode_t mode,
                                                   logic [tmc_pkg::CHAR_W-1:0] ch,
                                                   logic [tmc_pkg::INDEX_W-1:0] idx);
        console_view_t v;
        v.cell_word = '0;
        case (mode)
            tmc_pkg::MODE_PUT:  put_char(ch);
            tmc_pkg::MODE_READ: begin
                if (idx < STORE_CELLS) v.cell_word = screen[idx];
            end
            tmc_pkg::MODE_CLEAR: begin
                for (int i = 0; i < area_width() * area_height(); i++)
                    screen[i] = tmc_pkg::BLANK_CELL;
                cur_col = 0;
                cur_row = 0;
            end
            default: ;
        endcase
        v.col = tmc_pkg::COL_W'(cur_col);
        v.row = tmc_pkg::ROW_W'(cur_row);
        return v;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        console_view_t got;
        console_view_t want;
        if (!aresetn) begin
            foreach (screen[i]) screen[i] = tmc_pkg::BLANK_CELL;
            cur_col = 0;
            cur_row = 0;
            columns_reg = tmc_pkg::RST_COLUMNS;
            rows_reg = tmc_pkg::RST_ROWS;
            awaited_views.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == tmc_pkg::REG_COLUMNS) columns_reg = cfg_wdata;
                else rows_reg = cfg_wdata[tmc_pkg::ROW_W-1:0];
            end
            if (s_tvalid && s_tready)
                awaited_views.push_back(step_console(tmc_pkg::mode_t'(s_tuser),
                                                     s_tdata[7:0], s_tdata[18:8]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (awaited_views.size() == 0) begin
                    $display("%0t: result with no transfer waiting, expected none, got 0x%0h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = awaited_views.pop_front();
                    check_field("cell_value", int'(want.cell_word), int'(got.cell_word));
                    check_field("cursor_col", int'(want.col), int'(got.col));
                    check_field("cursor_row", int'(want.row), int'(got.row));
                end
            end
        end
        fail_count  <= mismatches;
        outstanding <= awaited_views.size();
    end

endmodule

FILE: sim/testbench.sv
// testbench: top of the text console simulation. Drives the input stream,
// the result-side ready and the register port, and prints the verdict.
// Depends on tmc_pkg, text_mode_console and console_checker.

module testbench;

    localparam int LIMIT_CYCLES  = 1_000_000;  // watchdog limit for the whole run
    localparam int HOLD_CYCLES   = 300;        // long result-side hold-off
    localparam int SETTLE_CYCLES = 16;         // settle time after the last result

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;   // [7:0] char_code, [18:8] cell_index
    logic [1:0]                s_tuser   = '0;   // [1:0] mode
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;          // [15:0] cell_value, [22:16] cursor_col,
                                                 // [27:23] cursor_row
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_addr  = tmc_pkg::REG_COLUMNS;
    logic [tmc_pkg::COL_W-1:0] cfg_wdata = '0;

    int   fail_count;
    int   outstanding;

    // traffic shaping knobs, changed per phase
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_req    = 1'b0;   // toggled by the stimulus to ask for a hold-off
    logic hold_ack    = 1'b0;
    int   hold_left   = 0;

    int   cycle_count = 0;
    int   items_sent  = 0;
    int   geometries  = 1;      // reset geometry counts as the first

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    text_mode_console dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    console_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result side: random stalls, or a long hold-off counted here when the
    // stimulus flips hold_req. The sender keeps pushing during the hold-off,
    // so the block's output register fills and s_tready has to drop.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("testbench: errors");
            $finish;
        end
    end

    // One transfer on the input stream. Called at a clock edge; returns at
    // the edge where the transfer was taken, with s_tvalid still high so
    // back-to-back items need no extra edge.
    task automatic send_item(input tmc_pkg::mode_t mode,
                             input logic [tmc_pkg::CHAR_W-1:0] ch,
                             input logic [tmc_pkg::INDEX_W-1:0] idx);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, idx, ch};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Random item for a w x h active area. Reads mostly land in the active
    // area so they see written text; some go anywhere, past the store too.
    task automatic send_random(input int w, input int h, input int clear_pct);
        tmc_pkg::mode_t               mode;
        logic [tmc_pkg::CHAR_W-1:0]   ch;
        logic [tmc_pkg::INDEX_W-1:0]  idx;
        int                           pick;
        pick = $urandom_range(99);
        if (pick < clear_pct)           mode = tmc_pkg::MODE_CLEAR;
        else if (pick < clear_pct + 5)  mode = tmc_pkg::MODE_NONE;
        else if (pick < clear_pct + 27) mode = tmc_pkg::MODE_READ;
        else                            mode = tmc_pkg::MODE_PUT;
        pick = $urandom_range(99);
        if (pick < 8)       ch = tmc_pkg::CH_LF;
        else if (pick < 14) ch = tmc_pkg::CH_CR;
        else if (pick < 20) ch = tmc_pkg::CH_BS;
        else if (pick < 23) ch = tmc_pkg::CH_NUL;
        else                ch = tmc_pkg::CHAR_W'($urandom_range(255));
        if ($urandom_range(3) == 0) idx = tmc_pkg::INDEX_W'($urandom_range(2047));
        else                        idx = tmc_pkg::INDEX_W'($urandom_range(w * h - 1));
        send_item(mode, ch, idx);
    endtask

    // Sender pause: drop valid, wait for every result, then let the block
    // finish its last cycles before any register write.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers in one burst so cfg_wr_en is never dropped and raised
    // in the same step.
    task automatic set_geometry(input logic [tmc_pkg::COL_W-1:0] col_val,
                                input logic [tmc_pkg::COL_W-1:0] row_val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= tmc_pkg::REG_COLUMNS;
        cfg_wdata <= col_val;
        @(posedge aclk);
        cfg_addr  <= tmc_pkg::REG_ROWS;
        cfg_wdata <= row_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        geometries++;
    endtask

    task automatic run_phase(input logic [tmc_pkg::COL_W-1:0] col_val,
                             input logic [tmc_pkg::COL_W-1:0] row_val,
                             input int w, input int h, input int idle, input int stall,
                             input int count);
        wait_results();
        set_geometry(col_val, row_val);
        idle_pct = idle;
        stall_pct <= stall;
        repeat (count) send_random(w, h, 4);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset geometry 80x25. The block blanks its store first,
        // so the first transfer simply waits for s_tready.
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd0);        // blank after reset
        send_item(tmc_pkg::MODE_READ, 8'hFF, 11'd1999);     // last cell of the store
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd2047);     // past the store: zero
        send_item(tmc_pkg::MODE_PUT, 8'h41, 11'd0);
        send_item(tmc_pkg::MODE_PUT, 8'hFF, 11'd0);         // high byte stays unsigned
        send_item(tmc_pkg::MODE_PUT, 8'h80, 11'd0);
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_NUL, 11'd0);   // no write, no move
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_BS, 11'd0);    // blanks cell 2
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_CR, 11'd0);
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_BS, 11'd0);    // at column 0: nothing
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_LF, 11'd0);
        send_item(tmc_pkg::MODE_NONE, 8'hFF, 11'h7FF);      // unused mode, cursor only
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd1);
        send_item(tmc_pkg::MODE_CLEAR, 8'h00, 11'd0);
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd0);

        // Directed, tiny 3x2 screen: pending wrap, wrap, scroll on newline.
        wait_results();
        set_geometry(7'd3, 7'd2);
        send_item(tmc_pkg::MODE_PUT, 8'h78, 11'd0);
        send_item(tmc_pkg::MODE_PUT, 8'h79, 11'd0);
        send_item(tmc_pkg::MODE_PUT, 8'h7A, 11'd0);         // column reaches width
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd2);        // reports the pending wrap
        send_item(tmc_pkg::MODE_PUT, 8'h77, 11'd0);         // wraps to row 1
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_LF, 11'd0);    // bottom row: scroll
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_BS, 11'd0);
        send_item(tmc_pkg::MODE_PUT, 8'h71, 11'd0);
        send_item(tmc_pkg::MODE_PUT, tmc_pkg::CH_BS, 11'd0);
        send_item(tmc_pkg::MODE_READ, 8'h00, 11'd0);        // scrolled-up text

        // Random phases: geometry, idle %, stall %, item count.
        run_phase(7'd5,   7'd3,  5,  3,  0,  0, 60);
        run_phase(7'd0,   7'd0,  1,  1, 52,  0, 30);   // zero registers act as 1
        run_phase(7'd16,  7'd4, 16,  4,  0, 52, 50);

        // Long result-side hold-off with the sender pushing back-to-back.
        wait_results();
        idle_pct = 0;
        stall_pct <= 0;
        hold_req <= ~hold_req;
        repeat (16) send_random(16, 4, 0);

        run_phase(7'd127, 7'd31, 80, 25, 37, 37, 25);  // clipped to the full store
        run_phase(7'd9,   7'h67,  9,  7, 37, 37, 50);  // row bits above 4 dropped
        run_phase(7'd1,   7'd25,  1, 25, 37, 37, 30);
        run_phase(7'd80,  7'd1,  80,  1,  0,  0, 30);

        wait_results();
        $display("summary: %0d transfers over %0d screen geometries, with wrap, scroll,",
                 items_sent, geometries);
        $display("  clear, clipped registers, shrink under the cursor and a long stall");
        if (fail_count == 0 && outstanding == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
